// File: rtl/dpq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpq_pkg
// Shared types and constants of the deadline priority queue.
// ----------------------------------------------------------------------------
package dpq_pkg;

    localparam int DEF_QUEUE_DEPTH = 16;
    localparam int DEF_TAG_BITS    = 16;

    localparam int TAG_W = 16;
    localparam int URG_W = 3;
    localparam int DUE_W = 31;
    localparam int STA_W = 2;
    localparam int DATA_W = 56;

    localparam logic REQ_PUSH = 1'b0;
    localparam logic REQ_POP  = 1'b1;

    typedef enum logic [STA_W-1:0] {
        ST_PUSHED   = 2'd0,
        ST_FULL     = 2'd1,
        ST_POPPED   = 2'd2,
        ST_EMPTY    = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_SHIFT
    } t_state;

endpackage

// File: rtl/dpq_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpq_mem
// Entry store: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module dpq_mem #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 50
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_q <= r_mem[i_raddr];
    end

    assign o_rdata = r_q;
endmodule

// File: rtl/deadline_priority_queue_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deadline_priority_queue_top
// Earliest-deadline-first task queue held in a single-port-read memory.
// ----------------------------------------------------------------------------
// Channel | Dir | tdata                                   | tuser
// s_axis  | in  | [15:0] tag, [18:16] urgency, [49:19] due | [0] req_type
// m_axis  | out | [15:0] tag, [18:16] urgency, [49:19] due | [1:0] status
//
// Push and empty pop: the result is registered in the cycle after accept.
// Pop: a scan of all stored entries (one memory read per cycle), then
// compacting the store, one entry moved per cycle.
// One item is in work at a time; input is taken only when idle and the
// result register is free or being drained. Reset empties the queue.
// ----------------------------------------------------------------------------
module deadline_priority_queue_top #(
    parameter int QUEUE_DEPTH = dpq_pkg::DEF_QUEUE_DEPTH,
    parameter int TAG_BITS    = dpq_pkg::DEF_TAG_BITS
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_s_axis_tvalid,
    output logic                       o_s_axis_tready,
    input  logic [dpq_pkg::DATA_W-1:0] i_s_axis_tdata,  // tag, urgency, due_time
    input  logic                       i_s_axis_tuser,  // req_type
    output logic                       o_m_axis_tvalid,
    input  logic                       i_m_axis_tready,
    output logic [dpq_pkg::DATA_W-1:0] o_m_axis_tdata,  // tag, urgency, due_time
    output logic [dpq_pkg::STA_W-1:0]  o_m_axis_tuser   // status
);
    import dpq_pkg::*;

    localparam int IW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int EW = TAG_BITS + URG_W + DUE_W;
    localparam logic [CW-1:0] FULL = CW'(QUEUE_DEPTH);

    t_state          r_state, n_state;
    logic [CW-1:0]   r_count, n_count;
    logic [IW-1:0]   r_idx, n_idx;
    logic [IW-1:0]   r_best, n_best;
    logic [EW-1:0]   r_bent, n_bent;
    logic            r_ovalid, n_ovalid;
    t_status         r_ostat, n_ostat;
    logic [EW-1:0]   r_oent, n_oent;

    logic            w_we;
    logic [IW-1:0]   w_waddr, w_raddr;
    logic [EW-1:0]   w_wdata, w_q, w_in_ent;
    logic [TAG_BITS-1:0] w_tag;
    logic [TAG_W-1:0]    w_otag;
    logic            w_acc, w_better, w_last;

    dpq_mem #(.DEPTH(QUEUE_DEPTH), .WIDTH(EW)) u_mem (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_q)
    );

    always_comb begin
        for (int b = 0; b < TAG_BITS; b++) begin
            w_tag[b] = (b < TAG_W) ? i_s_axis_tdata[b] : 1'b0;
        end
        for (int b = 0; b < TAG_W; b++) begin
            w_otag[b] = (b < TAG_BITS) ? r_oent[b] : 1'b0;
        end
    end

    assign w_in_ent = {i_s_axis_tdata[49:19], i_s_axis_tdata[18:16], w_tag};
    assign o_s_axis_tready = (r_state == S_IDLE) && (!r_ovalid || i_m_axis_tready);
    assign w_acc = i_s_axis_tvalid && o_s_axis_tready;

    // strict compare keeps the older (lower) slot on full ties
    assign w_better = (w_q[EW-1 -: DUE_W] < r_bent[EW-1 -: DUE_W]) ||
                      ((w_q[EW-1 -: DUE_W] == r_bent[EW-1 -: DUE_W]) &&
                       (w_q[TAG_BITS +: URG_W] < r_bent[TAG_BITS +: URG_W]));
    assign w_last = ((CW+1)'(r_idx) + (CW+1)'(1)) == (CW+1)'(r_count);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_ovalid <= n_ovalid;
        end
        r_idx   <= n_idx;
        r_best  <= n_best;
        r_bent  <= n_bent;
        r_ostat <= n_ostat;
        r_oent  <= n_oent;
    end

    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_idx    = r_idx;
        n_best   = r_best;
        n_bent   = r_bent;
        n_ovalid = r_ovalid && !i_m_axis_tready;
        n_ostat  = r_ostat;
        n_oent   = r_oent;
        w_we     = 1'b0;
        w_waddr  = r_idx;
        w_wdata  = w_q;
        w_raddr  = '0;
        unique case (r_state)
            S_IDLE: begin
                if (w_acc) begin
                    n_idx = '0;
                    if (i_s_axis_tuser == REQ_PUSH) begin
                        n_ovalid = 1'b1;
                        n_oent   = '0;
                        if (r_count == FULL) begin
                            n_ostat = ST_FULL;
                        end else begin
                            w_we    = 1'b1;
                            w_waddr = r_count[IW-1:0];
                            w_wdata = w_in_ent;
                            n_count = r_count + CW'(1);
                            n_ostat = ST_PUSHED;
                        end
                    end else if (r_count == '0) begin
                        n_ovalid = 1'b1;
                        n_ostat  = ST_EMPTY;
                        n_oent   = '0;
                    end else begin
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                // w_q holds slot r_idx
                if (r_idx == '0 || w_better) begin
                    n_best = r_idx;
                    n_bent = w_q;
                end
                if (w_last) begin
                    n_oent  = (r_idx == '0 || w_better) ? w_q : r_bent;
                    n_idx   = (r_idx == '0 || w_better) ? r_idx : r_best;
                    w_raddr = n_idx + IW'(1);
                    if (n_idx == r_idx) begin
                        n_state  = S_IDLE;
                        n_ovalid = 1'b1;
                        n_ostat  = ST_POPPED;
                        n_count  = r_count - CW'(1);
                    end else begin
                        n_state = S_SHIFT;
                    end
                end else begin
                    n_idx   = r_idx + IW'(1);
                    w_raddr = n_idx;
                end
            end
            S_SHIFT: begin
                // move slot r_idx+1 down into r_idx
                w_we    = 1'b1;
                w_waddr = r_idx;
                w_wdata = w_q;
                n_idx   = r_idx + IW'(1);
                w_raddr = r_idx + IW'(2);
                if (((CW+1)'(r_idx) + (CW+1)'(2)) == (CW+1)'(r_count)) begin
                    n_state  = S_IDLE;
                    n_ovalid = 1'b1;
                    n_ostat  = ST_POPPED;
                    n_count  = r_count - CW'(1);
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tuser  = r_ostat;
    assign o_m_axis_tdata  = {{(DATA_W-TAG_W-URG_W-DUE_W){1'b0}},
                              r_oent[EW-1 -: DUE_W], r_oent[TAG_BITS +: URG_W], w_otag};

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL) else $error("entry count beyond depth");
    a_busy_no_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !o_s_axis_tready)
        else $error("input taken while busy");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && !i_m_axis_tready) |=> (r_ovalid && $stable(r_ostat)))
        else $error("stalled result dropped");
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_count != '0))
        else $error("scan on empty queue");
endmodule

// File: sim/deadline_priority_queue_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deadline_priority_queue_top_test
// Self-checking bench for the earliest-deadline-first queue: a local model
// of the store predicts every result, directed corner cases come
// first, then random push/pop traffic under varied stream backpressure.
// ----------------------------------------------------------------------------
module deadline_priority_queue_top_test;
    import dpq_pkg::*;

    localparam int DEPTH = DEF_QUEUE_DEPTH;

    typedef struct packed {
        logic [TAG_W-1:0] tag;
        logic [URG_W-1:0] urg;
        logic [DUE_W-1:0] due;
    } t_task;

    typedef struct packed {
        t_status          status;
        logic [TAG_W-1:0] tag;
        logic [URG_W-1:0] urg;
        logic [DUE_W-1:0] due;
    } t_result;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [DATA_W-1:0]   s_tdata = '0;
    logic                s_tuser = 1'b0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [DATA_W-1:0]   m_tdata;
    logic [STA_W-1:0]    m_tuser;

    t_task   task_store[$];
    t_result pending_results[$];
    int      error_count = 0;
    int      result_count = 0;
    int      push_count = 0;
    int      pop_count = 0;
    int      send_idle_pct = 0;
    int      recv_idle_pct = 0;
    int      hold_cycles = 0;

    always #2 i_clk = ~i_clk;

    deadline_priority_queue_top i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_s_axis_tvalid(s_tvalid),
        .o_s_axis_tready(s_tready),
        .i_s_axis_tdata (s_tdata),   // tag, urgency, due_time
        .i_s_axis_tuser (s_tuser),   // req_type
        .o_m_axis_tvalid(m_tvalid),
        .i_m_axis_tready(m_tready),
        .o_m_axis_tdata (m_tdata),   // tag, urgency, due_time
        .o_m_axis_tuser (m_tuser)    // status
    );

    // Earliest deadline, then lowest urgency, then oldest entry.
    function automatic t_result serve_request(logic req, t_task t);
        t_result r;
        int      best;
        r = '0;
        if (req == REQ_PUSH) begin
            if (task_store.size() >= DEPTH) begin
                r.status = ST_FULL;
            end else begin
                task_store.push_back(t);
                r.status = ST_PUSHED;
            end
        end else if (task_store.size() == 0) begin
            r.status = ST_EMPTY;
        end else begin
            best = 0;
            for (int i = 1; i < task_store.size(); i++) begin
                if (task_store[i].due < task_store[best].due ||
                    (task_store[i].due == task_store[best].due &&
                     task_store[i].urg < task_store[best].urg))
                    best = i;
            end
            r.status = ST_POPPED;
            r.tag = task_store[best].tag;
            r.urg = task_store[best].urg;
            r.due = task_store[best].due;
            task_store.delete(best);
        end
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("MISMATCH %s: got %0h expected %0h", what, got, want);
        error_count++;
    endtask

    task automatic send_request(logic req, t_task t);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            @(posedge i_clk);
            s_tvalid <= 1'b0;
        end
        @(posedge i_clk);
        s_tvalid <= 1'b1;
        s_tuser  <= req;
        s_tdata  <= {{(DATA_W-50){1'b0}}, t.due, t.urg, t.tag};
        do @(posedge i_clk); while (!s_tready);
        pending_results.push_back(serve_request(req, t));
        if (req == REQ_PUSH) push_count++; else pop_count++;
        s_tvalid <= 1'b0;
    endtask

    // Receiver ready; a nonzero hold count holds it off until the count runs down to zero.
    always @(posedge i_clk) begin
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= !(recv_idle_pct > 0 && $urandom_range(99) < recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && m_tvalid && m_tready) begin
            result_count++;
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected result", m_tuser, 0);
            end else begin
                want = pending_results.pop_front();
                if (m_tuser !== want.status) report_mismatch("status", m_tuser, want.status);
                if (m_tdata[15:0] !== want.tag) report_mismatch("tag", m_tdata[15:0], want.tag);
                if (m_tdata[18:16] !== want.urg)
                    report_mismatch("urgency", m_tdata[18:16], want.urg);
                if (m_tdata[49:19] !== want.due)
                    report_mismatch("due_time", m_tdata[49:19], want.due);
            end
        end
    end

    function automatic t_task rand_task(bit few_dues);
        t_task t;
        t.tag = 16'($urandom);
        t.urg = ($urandom_range(9) == 0) ? 3'($urandom_range(7)) : 3'($urandom_range(5, 1));
        t.due = few_dues ? 31'($urandom_range(3)) : 31'($urandom);
        return t;
    endfunction

    task automatic wait_drained();
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic test_directed();
        t_task t;
        send_request(REQ_POP, '1);                // pop on empty
        send_request(REQ_PUSH, '{16'hFFFF, 3'd5, 31'h7FFF_FFFF});
        send_request(REQ_PUSH, '{16'h0000, 3'd1, 31'h7FFF_FFFF});
        send_request(REQ_PUSH, '{16'h1234, 3'd0, 31'd0});
        send_request(REQ_PUSH, '{16'h5555, 3'd7, 31'd0});
        send_request(REQ_PUSH, '{16'hAAAA, 3'd7, 31'd0}); // full tie, older wins
        for (int i = 0; i < 5; i++) send_request(REQ_POP, '0);
        for (int i = 0; i < DEPTH + 2; i++) begin   // fill up, then rejected pushes
            t = '{16'(i), 3'($urandom_range(5, 1)), 31'($urandom_range(4))};
            send_request(REQ_PUSH, t);
        end
        wait_drained();
        for (int i = 0; i < DEPTH + 1; i++) send_request(REQ_POP, '1);
        wait_drained();
    endtask

    task automatic test_random(int n);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(99) < (task_store.size() < 4 ? 70 : 45))
                send_request(REQ_PUSH, rand_task($urandom_range(1) == 0));
            else
                send_request(REQ_POP, rand_task(1'b0));
        end
        wait_drained();
    endtask

    task automatic test_backpressure();
        @(posedge i_clk);
        hold_cycles <= 300;
        for (int i = 0; i < DEPTH + 6; i++) send_request(REQ_PUSH, rand_task(1'b1));
        wait_drained();
        for (int i = 0; i < DEPTH + 2; i++) send_request(REQ_POP, '0);
        wait_drained();
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        send_idle_pct = 34; recv_idle_pct = 51;
        test_random(330);
        send_idle_pct = 51; recv_idle_pct = 34;
        test_random(330);
        send_idle_pct = 0; recv_idle_pct = 0;
        test_backpressure();
        test_random(330);
        repeat (4 * DEPTH + 10) @(posedge i_clk);
        $display("Covered %0d pushes and %0d pops, %0d results, incl. full/empty and ties.",
                 push_count, pop_count, result_count);
        if (error_count == 0 && pending_results.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

// File: sim.f
rtl/dpq_pkg.sv
rtl/dpq_mem.sv
rtl/deadline_priority_queue_top.sv
sim/deadline_priority_queue_top_test.sv
